FILE: rtl/core/key_event_hold_timer_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the key event hold timer.
// Each macro checks a clocked property on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KEY_EVENT_HOLD_TIMER_TOP_DEFINES_SVH
`define KEY_EVENT_HOLD_TIMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define KEHT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key event hold timer: check failed");
`define KEHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key event hold timer: check failed");
`else
`define KEHT_ASSERT_NOW(lbl, ante, cons)
`define KEHT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/keht_pkg.sv
// ---------------------------------------------------------------------------
// keht_pkg
// Types and constants shared by the key event hold timer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package keht_pkg;

    localparam int CODE_W = 7;
    localparam int TIME_W = 32;

    localparam logic [CODE_W-1:0] KEY_WIN    = 7'h5B;
    localparam logic [CODE_W-1:0] KEY_LSHIFT = 7'h2A;
    localparam logic [CODE_W-1:0] KEY_RSHIFT = 7'h36;
    localparam logic [CODE_W-1:0] KEY_SPACE  = 7'h39;
    localparam logic [CODE_W-1:0] KEY_CAPS   = 7'h3A;

    localparam logic [2:0] CAPS_OFF       = 3'd0;
    localparam logic [2:0] CAPS_FIRST_DN  = 3'd1;
    localparam logic [2:0] CAPS_LOCKED    = 3'd3;
    localparam logic [2:0] CAPS_SECOND_DN = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_EMIT
    } fsm_state_t;

    typedef struct packed {
        logic              press_en;
        logic              release_en;
        logic [CODE_W-1:0] code;
    } mod_event_t;

    typedef struct packed {
        logic       shift_held;
        logic [2:0] caps_phase;
        logic       win_held;
        logic       alt_layout;
    } mod_state_t;

    typedef struct packed {
        logic [1:0]        case_layout;
        logic [TIME_W-1:0] sequence_no;
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] interval;
    } slot_entry_t;

endpackage

FILE: rtl/core/keht_mod_track.sv
// ---------------------------------------------------------------------------
// keht_mod_track
// Tracks Shift, Win, the CapsLock phase and the layout toggle, and gives the
// case and layout code that a press of the current key would carry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_event_hold_timer_top_defines.svh"

module keht_mod_track (
    input  logic                 clk,
    input  logic                 rst_n,
    input  keht_pkg::mod_event_t ev,
    output logic [1:0]           press_case
);

    keht_pkg::mod_state_t mods_reg;
    keht_pkg::mod_state_t mods_next;
    keht_pkg::mod_state_t press_mods;
    keht_pkg::mod_state_t rel_mods;

    always_comb
    begin
        press_mods = mods_reg;
        unique case (ev.code)
            keht_pkg::KEY_WIN:    press_mods.win_held = 1'b1;
            keht_pkg::KEY_LSHIFT: press_mods.shift_held = 1'b1;
            keht_pkg::KEY_RSHIFT: press_mods.shift_held = 1'b1;
            keht_pkg::KEY_CAPS:
            begin
                if (mods_reg.caps_phase == keht_pkg::CAPS_LOCKED)
                begin
                    press_mods.caps_phase = keht_pkg::CAPS_SECOND_DN;
                end
                else if (mods_reg.caps_phase == keht_pkg::CAPS_OFF)
                begin
                    press_mods.caps_phase = keht_pkg::CAPS_FIRST_DN;
                end
            end
            default: press_mods = mods_reg;
        endcase

        rel_mods = mods_reg;
        unique case (ev.code)
            keht_pkg::KEY_WIN:    rel_mods.win_held = 1'b0;
            keht_pkg::KEY_LSHIFT: rel_mods.shift_held = 1'b0;
            keht_pkg::KEY_RSHIFT: rel_mods.shift_held = 1'b0;
            keht_pkg::KEY_SPACE:  rel_mods.alt_layout = mods_reg.alt_layout ^ mods_reg.win_held;
            keht_pkg::KEY_CAPS:
            begin
                if (mods_reg.caps_phase == keht_pkg::CAPS_FIRST_DN)
                begin
                    rel_mods.caps_phase = keht_pkg::CAPS_LOCKED;
                end
                else if (mods_reg.caps_phase == keht_pkg::CAPS_SECOND_DN)
                begin
                    rel_mods.caps_phase = keht_pkg::CAPS_OFF;
                end
            end
            default: rel_mods = mods_reg;
        endcase

        priority if (ev.release_en)
        begin
            mods_next = rel_mods;
        end
        else if (ev.press_en)
        begin
            mods_next = press_mods;
        end
        else
        begin
            mods_next = mods_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg <= '0;
        end
        else
        begin
            mods_reg <= mods_next;
        end
    end

    assign press_case = {press_mods.alt_layout,
                         press_mods.shift_held ^ press_mods.caps_phase[0]};

    `KEHT_ASSERT_NOW(a_caps_phase_legal, 1'b1, (mods_reg.caps_phase == keht_pkg::CAPS_OFF) || (mods_reg.caps_phase == keht_pkg::CAPS_FIRST_DN) || (mods_reg.caps_phase == keht_pkg::CAPS_LOCKED) || (mods_reg.caps_phase == keht_pkg::CAPS_SECOND_DN))
    `KEHT_ASSERT_NOW(a_one_event, 1'b1, !(ev.press_en && ev.release_en))

endmodule

FILE: rtl/core/key_event_hold_timer_top.sv
// ---------------------------------------------------------------------------
// key_event_hold_timer_top
// Keyboard event timer: keeps a table of held keys, reports presses with the
// case/layout state and the interval since the last press, and reports
// releases with the hold time.
//
//   Channel  Handshake        Beat content
//   input    start, busy      raw_code, now_ms
//   result   done (strobe)    key_code, is_release, case_layout,
//                             sequence_res, hold_ms, interval_ms
//
// An item scans the slot table through the code memory, one slot per cycle
// with a registered read, and stops at the first match; an item without a
// match gives no result. A press takes the first free slot, a release the
// slot that holds its code. The result strobe follows the last busy cycle,
// and a new start may be taken while it shows. Reset empties the table at
// once through per-slot flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_event_hold_timer_top_defines.svh"

module key_event_hold_timer_top #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  raw_code,
    input  logic [31:0] now_ms,
    output logic        done,
    output logic [6:0]  key_code,
    output logic        is_release,
    output logic [1:0]  case_layout,
    output logic [31:0] sequence_res,
    output logic [31:0] hold_ms,
    output logic [31:0] interval_ms
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    keht_pkg::fsm_state_t state_reg;
    keht_pkg::fsm_state_t state_next;

    logic [keht_pkg::CODE_W-1:0] code_mem [0:SLOTS-1];
    keht_pkg::slot_entry_t       pay_mem  [0:SLOTS-1];

    logic [SLOTS-1:0]            valid_reg;
    logic [CNT_W-1:0]            issue_cnt_reg;
    logic                        pend_reg;
    logic [IDX_W-1:0]            pend_idx_reg;
    logic [keht_pkg::CODE_W-1:0] code_rd_reg;
    logic [IDX_W-1:0]            slot_reg;
    keht_pkg::slot_entry_t       pay_rd_reg;
    logic [keht_pkg::CODE_W-1:0] code_reg;
    logic                        is_rel_reg;
    logic [31:0]                 now_reg;
    logic [31:0]                 press_count_reg;
    logic [31:0]                 last_press_reg;
    logic                        done_reg;
    logic                        done_next;

    logic [6:0]                  key_code_reg;
    logic                        is_release_reg;
    logic [1:0]                  case_layout_reg;
    logic [31:0]                 sequence_reg;
    logic [31:0]                 hold_reg;
    logic [31:0]                 interval_reg;

    logic                        accept;
    logic                        issue;
    logic                        hit;
    logic                        press_hit;
    logic                        last_cmp;
    logic [31:0]                 gap;
    logic [31:0]                 hold_raw;
    logic [31:0]                 hold_val;
    keht_pkg::mod_event_t        mod_ev;
    logic [1:0]                  press_case;

    assign busy     = (state_reg != keht_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign issue    = (state_reg == keht_pkg::ST_SCAN) && (issue_cnt_reg != CNT_W'(SLOTS));
    assign last_cmp = (pend_idx_reg == IDX_W'(SLOTS - 1));
    assign hit      = (state_reg == keht_pkg::ST_SCAN) && pend_reg &&
                      (is_rel_reg ? (valid_reg[pend_idx_reg] && (code_rd_reg == code_reg))
                                  : !valid_reg[pend_idx_reg]);
    assign press_hit = hit && !is_rel_reg;
    assign gap       = now_reg - last_press_reg;
    assign hold_raw  = now_reg - pay_rd_reg.press_time;
    assign hold_val  = (hold_raw == 32'd0) ? 32'd1 : hold_raw;

    assign mod_ev.release_en = accept && raw_code[7];
    assign mod_ev.press_en   = press_hit;
    assign mod_ev.code       = accept ? raw_code[6:0] : code_reg;

    keht_mod_track u_mod_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev         (mod_ev),
        .press_case (press_case)
    );

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            keht_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = keht_pkg::ST_SCAN;
                end
            end
            keht_pkg::ST_SCAN:
            begin
                priority if (hit)
                begin
                    state_next = is_rel_reg ? keht_pkg::ST_FETCH : keht_pkg::ST_IDLE;
                    done_next  = !is_rel_reg;
                end
                else if (pend_reg && last_cmp)
                begin
                    state_next = keht_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = keht_pkg::ST_SCAN;
                end
            end
            keht_pkg::ST_FETCH:
            begin
                state_next = keht_pkg::ST_EMIT;
            end
            keht_pkg::ST_EMIT:
            begin
                state_next = keht_pkg::ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = keht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= keht_pkg::ST_IDLE;
            done_reg        <= 1'b0;
            valid_reg       <= '0;
            issue_cnt_reg   <= '0;
            pend_reg        <= 1'b0;
            press_count_reg <= '0;
            last_press_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pend_reg  <= issue;
            if (accept)
            begin
                issue_cnt_reg <= '0;
                if (!raw_code[7])
                begin
                    press_count_reg <= press_count_reg + 32'd1;
                end
            end
            else if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            if (press_hit)
            begin
                valid_reg[pend_idx_reg] <= 1'b1;
                last_press_reg          <= now_reg;
            end
            else if (state_reg == keht_pkg::ST_EMIT)
            begin
                valid_reg[slot_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg   <= raw_code[6:0];
            is_rel_reg <= raw_code[7];
            now_reg    <= now_ms;
        end
        if (issue)
        begin
            pend_idx_reg <= issue_cnt_reg[IDX_W-1:0];
        end
        if (hit)
        begin
            slot_reg <= pend_idx_reg;
        end
        if (press_hit)
        begin
            key_code_reg    <= code_reg;
            is_release_reg  <= 1'b0;
            case_layout_reg <= press_case;
            sequence_reg    <= press_count_reg;
            hold_reg        <= 32'd0;
            interval_reg    <= gap;
        end
        else if (state_reg == keht_pkg::ST_EMIT)
        begin
            key_code_reg    <= code_reg;
            is_release_reg  <= 1'b1;
            case_layout_reg <= pay_rd_reg.case_layout;
            sequence_reg    <= pay_rd_reg.sequence_no;
            hold_reg        <= hold_val;
            interval_reg    <= pay_rd_reg.interval;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            code_rd_reg <= code_mem[issue_cnt_reg[IDX_W-1:0]];
        end
        if (press_hit)
        begin
            code_mem[pend_idx_reg] <= code_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == keht_pkg::ST_FETCH)
        begin
            pay_rd_reg <= pay_mem[slot_reg];
        end
        if (press_hit)
        begin
            pay_mem[pend_idx_reg] <= '{case_layout: press_case,
                                       sequence_no: press_count_reg,
                                       press_time:  now_reg,
                                       interval:    gap};
        end
    end

    assign done         = done_reg;
    assign key_code     = key_code_reg;
    assign is_release   = is_release_reg;
    assign case_layout  = case_layout_reg;
    assign sequence_res = sequence_reg;
    assign hold_ms      = hold_reg;
    assign interval_ms  = interval_reg;

    `KEHT_ASSERT_NEXT(a_accept_scans, accept, state_reg == keht_pkg::ST_SCAN)
    `KEHT_ASSERT_NEXT(a_emit_strobes, state_reg == keht_pkg::ST_EMIT, done_reg && is_release_reg)
    `KEHT_ASSERT_NOW(a_release_hold, done_reg && is_release_reg, hold_reg != 32'd0)
    `KEHT_ASSERT_NOW(a_press_hold, done_reg && !is_release_reg, hold_reg == 32'd0)
    `KEHT_ASSERT_NEXT(a_press_marks, press_hit, valid_reg[slot_reg])

endmodule

FILE: tb/sv/key_event_hold_timer_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key event hold timer testbench
// Drives scancode beats with timestamps into the hold timer and checks every
// reported press and release against a predictor of the held-key table and
// the Shift, CapsLock, Win and layout state. A short directed sequence comes
// first, then random typing in three phases with different sender idling.
// ---------------------------------------------------------------------------

module key_event_hold_timer_top_tb;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;
    localparam logic KEY_DN    = 1'b0;
    localparam logic KEY_UP    = 1'b1;

    typedef struct packed {
        logic [6:0]  key;
        logic        rel;
        logic [1:0]  cl;
        logic [31:0] seq;
        logic [31:0] hold;
        logic [31:0] gap;
    } key_event_t;

    typedef struct {
        logic [7:0]  raw;
        logic [31:0] ms;
        int unsigned idle_pct;
        bit          drain_first;
    } scan_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  raw_code = 8'h00;
    logic [31:0] now_ms = 32'h0;
    logic        done;
    logic [6:0]  key_code;
    logic        is_release;
    logic [1:0]  case_layout;
    logic [31:0] sequence_res;
    logic [31:0] hold_ms;
    logic [31:0] interval_ms;

    scan_beat_t  pending_beats [$];
    key_event_t  expected_events [$];
    logic [6:0]  held_keys [$];
    bit          beat_taken = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned cur_idle_pct = 0;
    bit          drain_next = 1'b0;
    logic [31:0] gen_ms = 32'h0;

    logic                 slot_used [SLOTS] = '{default: 1'b0};
    logic [6:0]           slot_key [SLOTS];
    logic [1:0]           slot_cl [SLOTS];
    logic [31:0]          slot_seq [SLOTS];
    logic [31:0]          slot_t0 [SLOTS];
    logic [31:0]          slot_gap [SLOTS];
    keht_pkg::mod_state_t mods = '0;
    logic [31:0]          presses_seen = 32'h0;
    logic [31:0]          last_press_ms = 32'h0;

    key_event_hold_timer_top #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .raw_code(raw_code),
        .now_ms(now_ms),
        .done(done),
        .key_code(key_code),
        .is_release(is_release),
        .case_layout(case_layout),
        .sequence_res(sequence_res),
        .hold_ms(hold_ms),
        .interval_ms(interval_ms)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit predict_key_event(input logic [7:0] raw, input logic [31:0] stamp,
                                             output key_event_t ev);
        logic [6:0] code;
        int         slot;
        code = raw[6:0];
        slot = -1;
        ev = '0;
        ev.key = code;
        if (raw[7])
        begin
            case (code)
                keht_pkg::KEY_WIN: mods.win_held = 1'b0;
                keht_pkg::KEY_LSHIFT, keht_pkg::KEY_RSHIFT: mods.shift_held = 1'b0;
                keht_pkg::KEY_SPACE: if (mods.win_held) mods.alt_layout = ~mods.alt_layout;
                keht_pkg::KEY_CAPS:
                begin
                    if (mods.caps_phase == keht_pkg::CAPS_FIRST_DN)
                        mods.caps_phase = keht_pkg::CAPS_LOCKED;
                    else if (mods.caps_phase == keht_pkg::CAPS_SECOND_DN)
                        mods.caps_phase = keht_pkg::CAPS_OFF;
                end
                default: ;
            endcase
            for (int k = SLOTS - 1; k >= 0; k--)
                if (slot_used[k] && slot_key[k] == code)
                    slot = k;
            if (slot < 0)
                return 1'b0;
            ev.rel  = 1'b1;
            ev.cl   = slot_cl[slot];
            ev.seq  = slot_seq[slot];
            ev.hold = stamp - slot_t0[slot];
            if (ev.hold == 32'h0)
                ev.hold = 32'h1;
            ev.gap  = slot_gap[slot];
            slot_used[slot] = 1'b0;
            return 1'b1;
        end
        presses_seen = presses_seen + 32'h1;
        for (int k = SLOTS - 1; k >= 0; k--)
            if (!slot_used[k])
                slot = k;
        if (slot < 0)
            return 1'b0;
        case (code)
            keht_pkg::KEY_WIN: mods.win_held = 1'b1;
            keht_pkg::KEY_LSHIFT, keht_pkg::KEY_RSHIFT: mods.shift_held = 1'b1;
            keht_pkg::KEY_CAPS:
            begin
                if (mods.caps_phase == keht_pkg::CAPS_LOCKED)
                    mods.caps_phase = keht_pkg::CAPS_SECOND_DN;
                else if (mods.caps_phase == keht_pkg::CAPS_OFF)
                    mods.caps_phase = keht_pkg::CAPS_FIRST_DN;
            end
            default: ;
        endcase
        ev.rel = 1'b0;
        ev.cl  = {mods.alt_layout, mods.shift_held ^ mods.caps_phase[0]};
        ev.seq = presses_seen;
        ev.gap = stamp - last_press_ms;
        slot_used[slot] = 1'b1;
        slot_key[slot]  = code;
        slot_cl[slot]   = ev.cl;
        slot_seq[slot]  = presses_seen;
        slot_t0[slot]   = stamp;
        slot_gap[slot]  = ev.gap;
        last_press_ms   = stamp;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic add_item(input logic [7:0] raw, input logic [31:0] stamp);
        scan_beat_t b;
        b.raw = raw;
        b.ms = stamp;
        b.idle_pct = cur_idle_pct;
        b.drain_first = drain_next;
        drain_next = 1'b0;
        pending_beats.push_back(b);
    endtask

    task automatic directed_key(input logic [7:0] raw, input logic [31:0] step);
        gen_ms = gen_ms + step;
        add_item(raw, gen_ms);
    endtask

    task automatic push_key(input logic [7:0] raw);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            gen_ms = gen_ms;
        else if (r < 97)
            gen_ms = gen_ms + $urandom_range(1, 40);
        else
            gen_ms = $urandom();
        add_item(raw, gen_ms);
        if (!raw[7])
            held_keys.push_back(raw[6:0]);
        else
            for (int k = 0; k < held_keys.size(); k++)
                if (held_keys[k] == raw[6:0])
                begin
                    held_keys.delete(k);
                    break;
                end
    endtask

    function automatic logic [6:0] pick_modifier();
        case ($urandom_range(0, 4))
            0: return keht_pkg::KEY_WIN;
            1: return keht_pkg::KEY_LSHIFT;
            2: return keht_pkg::KEY_RSHIFT;
            3: return keht_pkg::KEY_SPACE;
            default: return keht_pkg::KEY_CAPS;
        endcase
    endfunction

    task automatic typing_phase(input int count);
        int n;
        int r;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                drain_next = 1'b1;
                repeat (SLOTS + 2)
                    push_key({KEY_DN, 7'($urandom_range(0, 127))});
                n += SLOTS + 2;
            end
            else if (r < 38 && held_keys.size() < SLOTS + 4)
            begin
                push_key({KEY_DN, 7'($urandom_range(0, 127))});
                n++;
            end
            else if (r < 72 && held_keys.size() != 0)
            begin
                push_key({KEY_UP, held_keys[$urandom_range(0, held_keys.size() - 1)]});
                n++;
            end
            else if (r < 86)
            begin
                push_key({1'($urandom_range(0, 1)), pick_modifier()});
                n++;
            end
            else
            begin
                push_key(8'($urandom_range(0, 255)));
                n++;
            end
        end
    endtask

    always @(negedge clk)
    begin : beat_driver
        if (rst_n && (!start || beat_taken))
        begin
            beat_taken = 1'b0;
            if (pending_beats.size() == 0)
                start <= 1'b0;
            else if (pending_beats[0].drain_first && (expected_events.size() != 0 || busy))
                start <= 1'b0;
            else if ($urandom_range(0, 99) < pending_beats[0].idle_pct)
                start <= 1'b0;
            else
            begin
                start    <= 1'b1;
                raw_code <= pending_beats[0].raw;
                now_ms   <= pending_beats[0].ms;
                void'(pending_beats.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        key_event_t want;
        key_event_t next_ev;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: result with no expectation, expected none, actual key %0h",
                             $time, key_code);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("key_code", 32'(want.key), 32'(key_code));
                    check_field("is_release", 32'(want.rel), 32'(is_release));
                    check_field("case_layout", 32'(want.cl), 32'(case_layout));
                    check_field("sequence_res", want.seq, sequence_res);
                    check_field("hold_ms", want.hold, hold_ms);
                    check_field("interval_ms", want.gap, interval_ms);
                end
            end
            if (start && !busy)
            begin
                beat_taken = 1'b1;
                if (predict_key_event(raw_code, now_ms, next_ev))
                    expected_events.push_back(next_ev);
            end
        end
    end

    initial
    begin
        cur_idle_pct = 19;
        add_item({KEY_DN, 7'h00}, 32'h0000_0000);
        add_item({KEY_UP, 7'h00}, 32'h0000_0000);
        add_item({KEY_DN, 7'h7F}, 32'hFFFF_FFFF);
        add_item({KEY_UP, 7'h7F}, 32'h0000_0005);
        gen_ms = 32'h0000_0005;
        directed_key({KEY_DN, keht_pkg::KEY_LSHIFT}, 3);
        directed_key({KEY_DN, 7'h10}, 2);
        directed_key({KEY_UP, keht_pkg::KEY_LSHIFT}, 4);
        directed_key({KEY_DN, keht_pkg::KEY_RSHIFT}, 1);
        directed_key({KEY_UP, keht_pkg::KEY_RSHIFT}, 1);
        directed_key({KEY_DN, keht_pkg::KEY_CAPS}, 7);
        directed_key({KEY_UP, keht_pkg::KEY_CAPS}, 7);
        directed_key({KEY_DN, 7'h11}, 1);
        directed_key({KEY_DN, keht_pkg::KEY_CAPS}, 3);
        directed_key({KEY_UP, keht_pkg::KEY_CAPS}, 3);
        directed_key({KEY_DN, keht_pkg::KEY_WIN}, 2);
        directed_key({KEY_DN, keht_pkg::KEY_SPACE}, 2);
        directed_key({KEY_UP, keht_pkg::KEY_SPACE}, 2);
        directed_key({KEY_UP, keht_pkg::KEY_WIN}, 2);
        directed_key({KEY_DN, 7'h12}, 2);
        directed_key({KEY_UP, 7'h20}, 9);
        directed_key({KEY_DN, 7'h13}, 1);
        directed_key({KEY_DN, 7'h13}, 0);
        directed_key({KEY_UP, 7'h13}, 5);
        directed_key({KEY_UP, keht_pkg::KEY_SPACE}, 1);

        // The timestamp starts just below the wrap point so the random part crosses it.
        gen_ms = 32'hFFFF_F000;
        drain_next = 1'b1;
        typing_phase(350);
        cur_idle_pct = 56;
        drain_next = 1'b1;
        typing_phase(350);
        cur_idle_pct = 0;
        drain_next = 1'b1;
        typing_phase(350);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || start || expected_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        if (expected_events.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected key %0h, actual none",
                     $time, expected_events.size(), expected_events[0].key);
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
